// ----- src/assert_macros.svh -----
// Assertion macros used by the rational ALU top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define RALU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define RALU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/ralu_pkg.sv -----
// Shared types and codes of the rational ALU.
package ralu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned DenW  = 63;
  localparam int unsigned CntW  = 6;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;

  typedef enum logic [1:0] {
    EOP_MUL,
    EOP_DIV,
    EOP_GCD
  } eng_op_t;

  typedef struct packed {
    logic    start;
    eng_op_t op;
  } eng_req_t;

  typedef struct packed {
    logic done;
    logic hi_nz;
  } eng_rsp_t;

endpackage

// ----- src/rational_alu_64_unit.sv -----
// Top level of the 64-bit rational ALU: handshakes and the operation sequencer.
//
// Usage. An input transfer on the in_ channel carries an operation in in_tuser
// (add, subtract, multiply or divide) and two signed rationals in in_tdata,
// each a two's complement numerator and a positive denominator. The block
// returns one result transfer on the out_ channel: the reduced numerator and
// denominator in out_tdata and a status code in out_tuser (ok, overflow or
// division by zero). On any error the result is 0/1.
// The block works on one item at a time: in_tready is high only while it is
// idle. The result is worked out by the shared iterative unit: two or three
// 64-step shift-add multiplies, a binary gcd and two 64-step restoring
// divisions. Zero divisor rejects go from the check straight to the result.
// The result is held in registers on out_tdata and out_tuser with out_tvalid
// high until the receiver takes it; a stall on out_tready simply holds the
// block in that state, and the next input is accepted in the following cycle.
// A synchronous active-low reset returns the sequencer to idle, with no result
// pending; the data registers are not reset.
module rational_alu_64_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: a_num[63:0], a_den[62:0], b_num[63:0], b_den[62:0], zero pad.
  input  logic [255:0] in_tdata,
  // Fields from bit 0 up: command[1:0].
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0 up: res_num[63:0], res_den[62:0], zero pad.
  output logic [127:0] out_tdata,
  // Fields from bit 0 up: status[1:0].
  output logic [1:0]   out_tuser
);

  `include "assert_macros.svh"

  localparam int unsigned W  = ralu_pkg::DataW;
  localparam int unsigned DW = ralu_pkg::DenW;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_P1, S_P2, S_P3, S_COMB, S_GCD, S_DVN, S_DVD, S_OUT
  } state_t;

  state_t        state_r;
  logic          wait_r;
  logic [1:0]    cmd_r;
  logic [W-1:0]  an_r, bn_r, ad_r, bd_r;
  logic [W-1:0]  p_r, q_r, n_r, d_r, g_r;
  logic [W-1:0]  res_num_r;
  logic [DW-1:0] res_den_r;
  logic [1:0]    status_r;

  ralu_pkg::eng_req_t eng_req;
  ralu_pkg::eng_rsp_t eng_rsp;
  logic [W-1:0]       eng_a, eng_b, eng_res;

  logic [W-1:0] an_mag, bn_mag, n_mag;
  logic         prod_neg, prod_ovf;
  logic [W-1:0] prod_val;
  logic [W-1:0] comb_sum;
  logic         comb_ovf;

  // Magnitude of a two's complement word; the most negative value maps to 2^63.
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    an_mag = mag(an_r);
    bn_mag = mag(bn_r);
    n_mag  = mag(n_r);

    eng_req.start = 1'b0;
    eng_req.op    = ralu_pkg::EOP_MUL;
    eng_a         = '0;
    eng_b         = '0;
    prod_neg      = 1'b0;
    case (state_r)
      S_P1: begin
        eng_a    = an_mag;
        eng_b    = (cmd_r == ralu_pkg::CMD_MUL) ? bn_mag : bd_r;
        prod_neg = an_r[W-1] ^ ((cmd_r == ralu_pkg::CMD_MUL) & bn_r[W-1]);
      end
      S_P2: begin
        eng_a    = bn_mag;
        eng_b    = ad_r;
        prod_neg = bn_r[W-1];
      end
      S_P3: begin
        eng_a    = ad_r;
        eng_b    = (cmd_r == ralu_pkg::CMD_DIV) ? bn_mag : bd_r;
        prod_neg = (cmd_r == ralu_pkg::CMD_DIV) & bn_r[W-1];
      end
      S_GCD: begin
        eng_req.op = ralu_pkg::EOP_GCD;
        eng_a      = n_mag;
        eng_b      = d_r;
      end
      S_DVN: begin
        eng_req.op = ralu_pkg::EOP_DIV;
        eng_a      = n_mag;
        eng_b      = g_r;
      end
      S_DVD: begin
        eng_req.op = ralu_pkg::EOP_DIV;
        eng_a      = d_r;
        eng_b      = g_r;
      end
      default: begin
      end
    endcase
    if (state_r inside {S_P1, S_P2, S_P3, S_GCD, S_DVN, S_DVD}) begin
      eng_req.start = !wait_r;
    end

    // A product fits when the high half is clear and the low half lies within
    // the signed range for the sign of the result.
    prod_ovf = eng_rsp.hi_nz |
               (prod_neg ? (eng_res[W-1] & (|eng_res[W-2:0])) : eng_res[W-1]);
    prod_val = prod_neg ? (~eng_res + 1'b1) : eng_res;

    if (cmd_r == ralu_pkg::CMD_SUB) begin
      comb_sum = p_r - q_r;
      comb_ovf = ((p_r[W-1] ^ q_r[W-1]) & (p_r[W-1] ^ comb_sum[W-1]));
    end else begin
      comb_sum = p_r + q_r;
      comb_ovf = (~(p_r[W-1] ^ q_r[W-1]) & (p_r[W-1] ^ comb_sum[W-1]));
    end
  end

  ralu_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .opa   (eng_a),
    .opb   (eng_b),
    .rsp   (eng_rsp),
    .res   (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r  <= 1'b0;
    end else begin
      if (eng_req.start) begin
        wait_r <= 1'b1;
      end else if (eng_rsp.done) begin
        wait_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            an_r    <= in_tdata[63:0];
            ad_r    <= {1'b0, in_tdata[126:64]};
            bn_r    <= in_tdata[190:127];
            bd_r    <= {1'b0, in_tdata[253:191]};
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          q_r <= '0;
          if (ad_r == '0 || bd_r == '0 ||
              (cmd_r == ralu_pkg::CMD_DIV && bn_r == '0)) begin
            res_num_r <= '0;
            res_den_r <= DW'(1);
            status_r  <= ralu_pkg::ST_DIVZERO;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_P1;
          end
        end
        S_P1, S_P2, S_P3: begin
          if (wait_r && eng_rsp.done) begin
            if (prod_ovf) begin
              res_num_r <= '0;
              res_den_r <= DW'(1);
              status_r  <= ralu_pkg::ST_OVERFLOW;
              state_r   <= S_OUT;
            end else if (state_r == S_P1) begin
              p_r     <= prod_val;
              state_r <= (cmd_r == ralu_pkg::CMD_ADD || cmd_r == ralu_pkg::CMD_SUB)
                         ? S_P2 : S_P3;
            end else if (state_r == S_P2) begin
              q_r     <= prod_val;
              state_r <= S_P3;
            end else begin
              d_r     <= prod_val;
              state_r <= S_COMB;
            end
          end
        end
        S_COMB: begin
          // Sum or difference for add and subtract, then the sign of a
          // negative denominator is moved onto the numerator.
          if ((cmd_r == ralu_pkg::CMD_ADD || cmd_r == ralu_pkg::CMD_SUB) && comb_ovf) begin
            res_num_r <= '0;
            res_den_r <= DW'(1);
            status_r  <= ralu_pkg::ST_OVERFLOW;
            state_r   <= S_OUT;
          end else if (d_r[W-1] && (d_r == SignBit || p_r == SignBit)) begin
            res_num_r <= '0;
            res_den_r <= DW'(1);
            status_r  <= ralu_pkg::ST_OVERFLOW;
            state_r   <= S_OUT;
          end else if (d_r[W-1]) begin
            n_r     <= ~p_r + 1'b1;
            d_r     <= ~d_r + 1'b1;
            state_r <= S_GCD;
          end else begin
            n_r     <= comb_sum;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (wait_r && eng_rsp.done) begin
            g_r     <= eng_res;
            state_r <= S_DVN;
          end
        end
        S_DVN: begin
          if (wait_r && eng_rsp.done) begin
            res_num_r <= n_r[W-1] ? (~eng_res + 1'b1) : eng_res;
            state_r   <= S_DVD;
          end
        end
        S_DVD: begin
          if (wait_r && eng_rsp.done) begin
            res_den_r <= eng_res[DW-1:0];
            status_r  <= ralu_pkg::ST_OK;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {1'b0, res_den_r, res_num_r};
  assign out_tuser  = status_r;

  // An error result is always 0/1.
  `RALU_ASSERT_IMPL(a_err_zero, out_tvalid && status_r != ralu_pkg::ST_OK, res_num_r == '0 && res_den_r == DW'(1), "error result is not 0/1")
  // A good result never carries a zero denominator.
  `RALU_ASSERT_IMPL(a_den_nz, out_tvalid && status_r == ralu_pkg::ST_OK, res_den_r != '0, "zero denominator on a good result")
  // The engine only finishes a job that the sequencer is waiting on.
  `RALU_ASSERT_IMPL(a_done_waited, eng_rsp.done, wait_r, "engine finished without a pending job")
  // Input and output are never offered at once.
  `RALU_ASSERT_ALWAYS(a_one_side, !(in_tready && out_tvalid), "input ready while a result is pending")

endmodule

// ----- src/ralu_engine.sv -----
// Shared iterative unit: shift-add multiply, restoring divide and binary gcd.
module ralu_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ralu_pkg::eng_req_t            req,
  input  logic [ralu_pkg::DataW-1:0]    opa,
  input  logic [ralu_pkg::DataW-1:0]    opb,
  output ralu_pkg::eng_rsp_t            rsp,
  output logic [ralu_pkg::DataW-1:0]    res
);

  localparam int unsigned W = ralu_pkg::DataW;

  logic                        busy_r;
  logic                        done_r;
  ralu_pkg::eng_op_t           op_r;
  logic [ralu_pkg::CntW-1:0]   cnt_r;
  logic [W-1:0]                x_r;
  logic [W-1:0]                y_r;
  logic [W-1:0]                m_r;

  logic [W:0]   mul_sum;
  logic [W:0]   div_rem;
  logic [W+1:0] div_diff;
  logic [W:0]   g_uv;
  logic [W:0]   g_vu;
  logic [W-1:0] g_fin;

  always_comb begin
    mul_sum  = {1'b0, x_r} + (y_r[0] ? {1'b0, m_r} : {(W+1){1'b0}});
    div_rem  = {x_r, y_r[W-1]};
    div_diff = {1'b0, div_rem} - {2'b00, m_r};
    g_uv     = {1'b0, x_r} - {1'b0, y_r};
    g_vu     = {1'b0, y_r} - {1'b0, x_r};
    g_fin    = ((x_r == '0) ? y_r : x_r) << cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        case (req.op)
          ralu_pkg::EOP_MUL: begin
            x_r <= '0;
            y_r <= opb;
            m_r <= opa;
          end
          ralu_pkg::EOP_DIV: begin
            x_r <= '0;
            y_r <= opa;
            m_r <= opb;
          end
          default: begin
            x_r <= opa;
            y_r <= opb;
            m_r <= '0;
          end
        endcase
      end else if (busy_r) begin
        case (op_r)
          ralu_pkg::EOP_MUL: begin
            x_r   <= mul_sum[W:1];
            y_r   <= {mul_sum[0], y_r[W-1:1]};
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == '1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ralu_pkg::EOP_DIV: begin
            if (!div_diff[W+1]) begin
              x_r <= div_diff[W-1:0];
            end else begin
              x_r <= div_rem[W-1:0];
            end
            y_r   <= {y_r[W-2:0], ~div_diff[W+1]};
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == '1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            if (x_r == '0 || y_r == '0) begin
              y_r    <= g_fin;
              x_r    <= '0;
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else if (!x_r[0] && !y_r[0]) begin
              x_r   <= x_r >> 1;
              y_r   <= y_r >> 1;
              cnt_r <= cnt_r + 1'b1;
            end else if (!x_r[0]) begin
              x_r <= x_r >> 1;
            end else if (!y_r[0]) begin
              y_r <= y_r >> 1;
            end else if (!g_uv[W]) begin
              x_r <= g_uv[W:1];
            end else begin
              y_r <= g_vu[W:1];
            end
          end
        endcase
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.hi_nz = |x_r;
  assign res       = y_r;

endmodule

// ----- bench/tb_rational_alu_64_unit.sv -----
// Self-checking bench for the 64-bit rational ALU: exact arithmetic against a local predictor.
`timescale 1ns / 1ps

module tb_rational_alu_64_unit;

  // One operation request: command and two rationals.
  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] an;
    logic [62:0] ad;
    logic [63:0] bn;
    logic [62:0] bd;
  } ratio_op_t;

  // One reduced answer with its status code.
  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  st;
  } ratio_ans_t;

  localparam int unsigned NumRandom = 1700;
  localparam longint unsigned CycleCap = 64'd3_000_000;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Max63 = 64'h7fff_ffff_ffff_ffff;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [1:0]   in_tuser = ralu_pkg::CMD_ADD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;

  ratio_op_t  pending_ops[$];
  ratio_ans_t awaited_answers[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  longint unsigned cycle_count = 0;
  bit stimulus_done = 1'b0;
  // Set by the stimulus process to hold the sender until all answers are back.
  bit hold_sender = 1'b0;
  // Once set, neither side starts a new random idle burst.
  bit calm_phase = 1'b0;

  rational_alu_64_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Signed multiply of two bit patterns; ok is cleared if it does not fit in 64 bits.
  function automatic logic [63:0] smul(logic [63:0] x, logic [63:0] y, inout bit ok);
    logic [127:0] p;
    bit neg;
    neg = x[63] ^ y[63];
    p = {64'd0, mag64(x)} * {64'd0, mag64(y)};
    if (p > (neg ? {64'd0, SignBit} : {64'd0, Max63})) ok = 1'b0;
    return neg ? -p[63:0] : p[63:0];
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Works out the reduced result of one operation, checks in the order zero divisor first.
  function automatic ratio_ans_t reduce_rational(ratio_op_t op);
    ratio_ans_t r;
    logic [63:0] ad, bd, p, q, n, d, g;
    logic [64:0] s;
    bit ok;
    ok = 1'b1;
    ad = {1'b0, op.ad};
    bd = {1'b0, op.bd};
    r.num = '0;
    r.den = 63'd1;
    r.st = ralu_pkg::ST_OK;
    if (ad == 0 || bd == 0 || (op.cmd == ralu_pkg::CMD_DIV && op.bn == 0)) begin
      r.st = ralu_pkg::ST_DIVZERO;
      return r;
    end
    case (op.cmd)
      ralu_pkg::CMD_ADD, ralu_pkg::CMD_SUB: begin
        p = smul(op.an, bd, ok);
        if (ok) q = smul(op.bn, ad, ok);
        if (ok) begin
          if (op.cmd == ralu_pkg::CMD_ADD) s = {p[63], p} + {q[63], q};
          else s = {p[63], p} - {q[63], q};
          if (s[64] != s[63]) ok = 1'b0;
          n = s[63:0];
        end
        if (ok) d = smul(ad, bd, ok);
      end
      ralu_pkg::CMD_MUL: begin
        n = smul(op.an, op.bn, ok);
        if (ok) d = smul(ad, bd, ok);
      end
      default: begin
        n = smul(op.an, bd, ok);
        if (ok) d = smul(ad, op.bn, ok);
        if (ok && d[63]) begin
          if (d == SignBit || n == SignBit) ok = 1'b0;
          d = -d;
          n = -n;
        end
      end
    endcase
    if (!ok) begin
      r.st = ralu_pkg::ST_OVERFLOW;
      return r;
    end
    g = gcd64(mag64(n), d);
    if (g == 0) g = 1;
    p = mag64(n) / g;
    r.num = n[63] ? -p : p;
    r.den = 63'(d / g);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Numerators mostly small so that products stay in range and reductions happen.
  function automatic logic [63:0] rand_num();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return 64'($signed($urandom_range(0, 2000)) - 1000);
    if (k < 8) return 64'($signed({1'b0, $urandom()}) - 64'sd2147483648);
    if (k < 9) return rand64();
    return $urandom_range(0, 1) ? SignBit : Max63;
  endfunction

  function automatic logic [62:0] rand_den();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 3) return 63'd1;
    if (k < 7) return 63'($urandom_range(1, 1000));
    if (k < 9) return 63'($urandom());
    return 63'(rand64());
  endfunction

  task automatic queue_op(logic [1:0] c, logic [63:0] an, logic [62:0] ad,
                          logic [63:0] bn, logic [62:0] bd);
    ratio_op_t op;
    op.cmd = c;
    op.an = an;
    op.ad = ad;
    op.bn = bn;
    op.bd = bd;
    pending_ops.push_back(op);
  endtask

  // Driver: takes the next request from the queue, with random idle bursts.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_ops.pop_front());
        if (!calm_phase && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
      end
      if (send_gap != 0 && !(in_tvalid && !in_tready)) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!(in_tvalid && !in_tready)) begin
        // Either idle or the last transfer just completed: present the next item.
        if (pending_ops.size() > 0 && !hold_sender) begin
          ratio_op_t nx;
          nx = pending_ops[0];
          in_tvalid <= 1'b1;
          in_tuser <= nx.cmd;
          in_tdata <= {2'b00, nx.bd, nx.bn, nx.ad, nx.an};
          awaited_answers.push_back(reduce_rational(nx));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted answer with the oldest prediction.
  int unsigned recv_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        ratio_ans_t exp_ans;
        if (awaited_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result transfer: %h / %h", out_tdata, out_tuser);
        end else begin
          exp_ans = awaited_answers.pop_front();
          checked_count++;
          if (out_tdata[63:0] !== exp_ans.num || out_tdata[126:64] !== exp_ans.den
              || out_tuser !== exp_ans.st) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                       $signed(exp_ans.num), exp_ans.den, exp_ans.st,
                       $signed(out_tdata[63:0]), out_tdata[126:64], out_tuser);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    if (cycle_count > CycleCap) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [1:0] c;
    int unsigned k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, every operation, zero divisors, overflow and sign fix-up.
    queue_op(ralu_pkg::CMD_ADD, 64'd1, 63'd2, 64'd1, 63'd3);
    queue_op(ralu_pkg::CMD_SUB, 64'd1, 63'd2, 64'd1, 63'd2);
    queue_op(ralu_pkg::CMD_MUL, -64'd6, 63'd4, 64'd2, 63'd3);
    queue_op(ralu_pkg::CMD_DIV, 64'd7, 63'd1, 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_DIV, 64'd3, 63'd5, -64'd9, 63'd10);
    queue_op(ralu_pkg::CMD_DIV, 64'd3, 63'd5, 64'd0, 63'd1);
    queue_op(ralu_pkg::CMD_ADD, 64'd3, 63'd0, 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_MUL, 64'd3, 63'd1, 64'd1, 63'd0);
    queue_op(ralu_pkg::CMD_ADD, Max63, 63'd1, 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_SUB, SignBit, 63'd1, 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_ADD, SignBit, 63'd1, 64'd0, 63'd1);
    queue_op(ralu_pkg::CMD_MUL, SignBit, 63'd1, -64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_DIV, SignBit, 63'd1, -64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_DIV, 64'd1, Max63[62:0], 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_MUL, 64'd1, Max63[62:0], 64'd1, 63'd2);
    queue_op(ralu_pkg::CMD_MUL, Max63, Max63[62:0], 64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_ADD, 64'd0, 63'd7, 64'd0, 63'd5);
    queue_op(ralu_pkg::CMD_SUB, -64'd1, 63'd1, Max63, 63'd1);
    queue_op(ralu_pkg::CMD_DIV, 64'd5, 63'd1, SignBit, 63'd1);
    queue_op(ralu_pkg::CMD_MUL, 64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
             64'd1, 63'd1);
    queue_op(ralu_pkg::CMD_MUL, 64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
             64'd1, 63'd1);

    // Hold the sender until every directed answer has returned.
    wait (pending_ops.size() == 0 && !in_tvalid);
    hold_sender = 1'b1;
    wait (awaited_answers.size() == 0);
    hold_sender = 1'b0;

    for (int i = 0; i < NumRandom; i++) begin
      c = 2'($urandom_range(0, 3));
      k = $urandom_range(0, 39);
      if (k == 0) queue_op(c, rand64(), 63'(rand64()), rand64(), 63'(rand64()));
      else if (k == 1) queue_op(c, rand_num(), 63'd0, rand_num(), rand_den());
      else if (k == 2) queue_op(ralu_pkg::CMD_DIV, rand_num(), rand_den(), 64'd0, rand_den());
      else queue_op(c, rand_num(), rand_den(), rand_num(), rand_den());
      if (i == NumRandom - 200) calm_phase = 1'b1;
      while (pending_ops.size() > 8) @(posedge clk);
    end

    wait (pending_ops.size() == 0 && !in_tvalid);
    stimulus_done = 1'b1;
    wait (awaited_answers.size() == 0);
    repeat (600) @(posedge clk);
    $display("Covered %0d checked results over add, subtract, multiply and divide,",
             checked_count);
    $display("including zero divisors, overflow and sign normalisation.");
    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ralu_pkg.sv
src/ralu_engine.sv
src/rational_alu_64_unit.sv
bench/tb_rational_alu_64_unit.sv
